// ===== rtl/core/scmc_pkg.sv =====
// ---------------------------------------------------------------------------
// scmc_pkg: shared types and constants for the compute module check
// Opcodes, error codes, register indexes, command bundle and FNV-1a step.
// ---------------------------------------------------------------------------
package scmc_pkg;

    localparam int NAME_BYTES_DEF = 16;

    localparam logic [31:0] SPV_MAGIC       = 32'h0723_0203;
    localparam logic [15:0] OP_ENTRY        = 16'd15;
    localparam logic [15:0] OP_MODE         = 16'd16;
    localparam logic [31:0] MODEL_GLCOMPUTE = 32'd5;
    localparam logic [31:0] MODE_LOCAL_SIZE = 32'd17;
    localparam logic [2:0]  HEADER_WORDS    = 3'd5;
    localparam logic [63:0] FNV_BASIS       = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHAPE    = 3'd1,
        ERR_MAGIC    = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_NO_ENTRY = 3'd4,
        ERR_NO_SIZE  = 3'd5,
        ERR_MISMATCH = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        REG_NAME_LOW  = 3'd0,
        REG_NAME_HIGH = 3'd1,
        REG_SIZE_X    = 3'd2,
        REG_SIZE_Y    = 3'd3,
        REG_SIZE_Z    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic       accept;
        logic       step;
        logic [1:0] byte_sel;
        logic       load;
    } scmc_cmd_t;

    // One FNV-1a byte step; the prime 2^40 + 0x1b3 is applied as shifts and adds.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] t;
        t = h ^ {56'd0, b};
        return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    endfunction

endpackage

// ===== rtl/core/spirv_compute_module_check.sv =====
// ---------------------------------------------------------------------------
// spirv_compute_module_check: SPIR-V compute entry point check with FNV-1a 64
// Walks a module word by word, matches the configured entry point and its
// LocalSize, and hashes every byte of the module.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one module word per beat (module_word, last_word), taken
//   when in_valid is high and in_stall low. Mark the final word with last_word.
//   Output channel: one result beat per module, on out_valid / out_stall; the
//   payload holds steady while stalled.
//   Configuration: write name and group size registers through cfg_write,
//   cfg_index and cfg_data while no module is in flight.
// Timing:
//   The FNV-1a unit steps one byte per cycle, the first byte in the accept
//   cycle, and in_stall stays high until all four bytes are hashed. After
//   the last word the sequencer waits in S_FINISH for a free output register,
//   then loads the result, which appears registered on out_valid.
//   A waiting result does not block the next word until the next module's
//   last word is hashed; then that result waits for the register to drain.
// Reset:
//   Clears the stream state, the hash to its offset basis, the name to zero
//   and the group sizes to one. Configuration survives the end of a module.
// ---------------------------------------------------------------------------
module spirv_compute_module_check
    import scmc_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] module_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        module_ok,
    output logic [2:0]  error_code,
    output logic [31:0] found_size_x,
    output logic [31:0] found_size_y,
    output logic [31:0] found_size_z,
    output logic [63:0] module_hash
);

    scmc_cmd_t cmd;

    // Sequencer: accept, hash steps, result load
    scmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_word (last_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Walk, match, hash and result register
    scmc_datapath #(
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .module_word  (module_word),
        .last_word    (last_word),
        .cmd          (cmd),
        .module_ok    (module_ok),
        .error_code   (error_code),
        .found_size_x (found_size_x),
        .found_size_y (found_size_y),
        .found_size_z (found_size_z),
        .module_hash  (module_hash)
    );

endmodule

// ===== rtl/core/scmc_ctrl.sv =====
// ---------------------------------------------------------------------------
// scmc_ctrl: sequencer for the compute module check
// Takes a beat, steps the hash over the remaining bytes, and after the last word loads the result.
// ---------------------------------------------------------------------------
module scmc_ctrl
    import scmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      last_word,
    output logic      out_valid,
    input  logic      out_stall,
    output scmc_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_HASH   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = 2'd1;
                    last_next  = last_word;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.step     = 1'b1;
                cmd.byte_sel = cnt_reg;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an untaken beat");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> in_stall)
        else $error("input not held off while hashing");
    a_finish_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> last_reg)
        else $error("finish reached without a last word");
`endif

endmodule

// ===== rtl/core/scmc_datapath.sv =====
// ---------------------------------------------------------------------------
// scmc_datapath: instruction walk, entry match, hash and result register
// Holds configuration, stream state and the output payload.
// ---------------------------------------------------------------------------
module scmc_datapath
    import scmc_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [31:0] module_word,
    input  logic        last_word,
    input  scmc_cmd_t   cmd,
    output logic        module_ok,
    output logic [2:0]  error_code,
    output logic [31:0] found_size_x,
    output logic [31:0] found_size_y,
    output logic [31:0] found_size_z,
    output logic [63:0] module_hash
);

    // Bytes at NAME_BYTES-1 and above always compare as zero.
    localparam int NB = NAME_BYTES - 1;
    localparam int IW = $clog2(NB);

    logic [NB-1:0][7:0] name_reg;
    logic [31:0]        gx_reg, gy_reg, gz_reg;

    logic [2:0]  wi_reg, wi_next;
    logic [15:0] wl_reg, wl_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic        c_entry_reg, c_entry_next;
    logic        c_ended_reg, c_ended_next;
    logic        c_mode_reg, c_mode_next;
    logic [31:0] ptid_reg, ptid_next;
    logic [31:0] ps_reg [3];
    logic [31:0] ps_next [3];
    logic        ef_reg, ef_next;
    logic [31:0] eid_reg, eid_next;
    logic        sf_reg, sf_next;
    logic [31:0] cs_reg [3];
    logic [31:0] cs_next [3];
    err_t        fe_reg, fe_next;
    logic [63:0] hash_reg;
    logic [31:0] word_reg;

    function automatic logic [7:0] pick(input logic [NB-1:0][7:0] nm, input logic [17:0] idx);
        logic [7:0] r;
        r = 8'd0;
        if (idx < 18'(NB))
        begin
            r = nm[idx[IW-1:0]];
        end
        return r;
    endfunction

    // Configuration
    for (genvar k = 0; k < NB; k++)
    begin : g_name
        if (k < 8)
        begin : g_low
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    name_reg[k] <= 8'd0;
                end
                else if (cfg_write && cfg_index == REG_NAME_LOW)
                begin
                    name_reg[k] <= cfg_data[8*k +: 8];
                end
            end
        end
        else
        begin : g_high
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    name_reg[k] <= 8'd0;
                end
                else if (cfg_write && cfg_index == REG_NAME_HIGH)
                begin
                    name_reg[k] <= cfg_data[8*(k-8) +: 8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= 32'd1;
            gy_reg <= 32'd1;
            gz_reg <= 32'd1;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SIZE_X) gx_reg <= cfg_data[31:0];
            if (cfg_index == REG_SIZE_Y) gy_reg <= cfg_data[31:0];
            if (cfg_index == REG_SIZE_Z) gz_reg <= cfg_data[31:0];
        end
    end

    // Walk one word
    always_comb
    begin
        logic        skip;
        logic        done;
        logic [17:0] base;
        logic [7:0]  c;
        wi_next      = wi_reg;
        wl_next      = wl_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        c_entry_next = c_entry_reg;
        c_ended_next = c_ended_reg;
        c_mode_next  = c_mode_reg;
        ptid_next    = ptid_reg;
        ps_next      = ps_reg;
        ef_next      = ef_reg;
        eid_next     = eid_reg;
        sf_next      = sf_reg;
        cs_next      = cs_reg;
        fe_next      = fe_reg;
        skip         = 1'b1;
        done         = 1'b0;
        base         = 18'd0;
        c            = 8'd0;

        if (fe_reg == ERR_NONE)
        begin
            if (wi_reg == 3'd0)
            begin
                if (module_word != SPV_MAGIC) fe_next = ERR_MAGIC;
            end
            else if (wi_reg >= HEADER_WORDS)
            begin
                skip = 1'b0;
                if (wl_reg == 16'd0)
                begin
                    if (module_word[31:16] == 16'd0)
                    begin
                        fe_next = ERR_LENGTH;
                        skip    = 1'b1;
                    end
                    else
                    begin
                        len_next     = module_word[31:16];
                        pos_next     = 16'd0;
                        wl_next      = module_word[31:16] - 16'd1;
                        c_entry_next = (module_word[15:0] == OP_ENTRY)
                                       && (module_word[31:16] >= 16'd4);
                        c_mode_next  = (module_word[15:0] == OP_MODE)
                                       && (module_word[31:16] == 16'd6);
                        c_ended_next = 1'b0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 16'd1;
                    wl_next  = wl_reg - 16'd1;
                    if (c_entry_next)
                    begin
                        if (pos_next == 16'd1)
                        begin
                            if (module_word != MODEL_GLCOMPUTE) c_entry_next = 1'b0;
                        end
                        else if (pos_next == 16'd2)
                        begin
                            ptid_next = module_word;
                        end
                        else if (!c_ended_next)
                        begin
                            base = (18'(pos_next) - 18'd3) << 2;
                            for (int b = 0; b < 4; b++)
                            begin
                                c = module_word[8*b +: 8];
                                if (!done)
                                begin
                                    if (c != pick(name_reg, base + 18'(b)))
                                    begin
                                        c_entry_next = 1'b0;
                                        done         = 1'b1;
                                    end
                                    else if (c == 8'd0)
                                    begin
                                        c_ended_next = 1'b1;
                                        done         = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    if (c_mode_next)
                    begin
                        case (pos_next)
                            16'd1: ptid_next = module_word;
                            16'd2: if (module_word != MODE_LOCAL_SIZE) c_mode_next = 1'b0;
                            16'd3: ps_next[0] = module_word;
                            16'd4: ps_next[1] = module_word;
                            16'd5: ps_next[2] = module_word;
                            default: ;
                        endcase
                    end
                end
            end
        end

        if (!skip && wl_next == 16'd0)
        begin
            if (c_entry_next && (c_ended_next
                || pick(name_reg, (18'(len_next) - 18'd3) << 2) == 8'd0))
            begin
                ef_next  = 1'b1;
                eid_next = ptid_next;
            end
            if (c_mode_next && ef_next && ptid_next == eid_next)
            begin
                cs_next = ps_next;
                sf_next = 1'b1;
            end
        end

        if (last_word)
        begin
            if (fe_next == ERR_NONE)
            begin
                if (wi_reg < 3'd4) fe_next = ERR_MAGIC;
                else if (wl_next != 16'd0) fe_next = ERR_LENGTH;
            end
        end
        else if (wi_reg != HEADER_WORDS)
        begin
            wi_next = wi_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg      <= 3'd0;
            wl_reg      <= 16'd0;
            pos_reg     <= 16'd0;
            len_reg     <= 16'd0;
            c_entry_reg <= 1'b0;
            c_ended_reg <= 1'b0;
            c_mode_reg  <= 1'b0;
            ptid_reg    <= 32'd0;
            ps_reg      <= '{default: 32'd0};
            ef_reg      <= 1'b0;
            eid_reg     <= 32'd0;
            sf_reg      <= 1'b0;
            cs_reg      <= '{default: 32'd0};
            fe_reg      <= ERR_NONE;
            hash_reg    <= FNV_BASIS;
        end
        else if (cmd.load)
        begin
            wi_reg      <= 3'd0;
            wl_reg      <= 16'd0;
            pos_reg     <= 16'd0;
            len_reg     <= 16'd0;
            c_entry_reg <= 1'b0;
            c_ended_reg <= 1'b0;
            c_mode_reg  <= 1'b0;
            ptid_reg    <= 32'd0;
            ps_reg      <= '{default: 32'd0};
            ef_reg      <= 1'b0;
            eid_reg     <= 32'd0;
            sf_reg      <= 1'b0;
            cs_reg      <= '{default: 32'd0};
            fe_reg      <= ERR_NONE;
            hash_reg    <= FNV_BASIS;
        end
        else if (cmd.accept)
        begin
            wi_reg      <= wi_next;
            wl_reg      <= wl_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            c_entry_reg <= c_entry_next;
            c_ended_reg <= c_ended_next;
            c_mode_reg  <= c_mode_next;
            ptid_reg    <= ptid_next;
            ps_reg      <= ps_next;
            ef_reg      <= ef_next;
            eid_reg     <= eid_next;
            sf_reg      <= sf_next;
            cs_reg      <= cs_next;
            fe_reg      <= fe_next;
            hash_reg    <= fnv_step(hash_reg, module_word[7:0]);
        end
        else if (cmd.step)
        begin
            hash_reg <= fnv_step(hash_reg, word_reg[8*cmd.byte_sel +: 8]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= module_word;
        end
    end

    // Result
    logic shape_bad;
    err_t err;

    always_comb
    begin
        shape_bad = (gx_reg == 32'd0) || (gy_reg == 32'd0) || (gz_reg == 32'd0)
                    || (name_reg[0] == 8'd0);
        if (shape_bad) err = ERR_SHAPE;
        else if (fe_reg != ERR_NONE) err = fe_reg;
        else if (!ef_reg) err = ERR_NO_ENTRY;
        else if (!sf_reg) err = ERR_NO_SIZE;
        else if (cs_reg[0] != gx_reg || cs_reg[1] != gy_reg || cs_reg[2] != gz_reg)
            err = ERR_MISMATCH;
        else err = ERR_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            module_ok    <= (err == ERR_NONE);
            error_code   <= err;
            found_size_x <= (!shape_bad && sf_reg) ? cs_reg[0] : 32'd0;
            found_size_y <= (!shape_bad && sf_reg) ? cs_reg[1] : 32'd0;
            found_size_z <= (!shape_bad && sf_reg) ? cs_reg[2] : 32'd0;
            module_hash  <= (err == ERR_NONE) ? hash_reg : 64'd0;
        end
    end

`ifndef SYNTHESIS
    a_first_error_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (fe_reg != ERR_NONE && !cmd.load) |=> (fe_reg == $past(fe_reg)))
        else $error("first error overwritten");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for the SPIR-V compute module check
// Streams SPIR-V modules, well formed and broken, one word per beat, under
// random idling on both channels and several register settings. A scoreboard
// predicts each result beat and compares it field by field.
// ---------------------------------------------------------------------------
module tb_top;
    import scmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        ok;
        err_t        code;
        logic [31:0] sx, sy, sz;
        logic [63:0] hash;
    } verdict_t;

    // Scoreboard: holds its own copy of the module walk and the registers.
    class module_scoreboard;
        logic [63:0] name_lo, name_hi;
        logic [31:0] gx, gy, gz;
        logic [31:0] widx;
        logic [15:0] left, pos, len;
        logic        c_entry, c_ended, c_mode;
        logic [31:0] pend_id, entry_id;
        logic [31:0] pend_sz[3], cap_sz[3];
        logic        entry_found, size_found;
        logic [2:0]  first_err;
        logic [63:0] hash;
        verdict_t    pending_q[$];
        int          errors;

        function new();
            name_lo = 0; name_hi = 0; gx = 1; gy = 1; gz = 1; errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            widx = 0; left = 0; pos = 0; len = 0;
            c_entry = 0; c_ended = 0; c_mode = 0;
            pend_id = 0; entry_id = 0; entry_found = 0; size_found = 0;
            for (int i = 0; i < 3; i++) begin pend_sz[i] = 0; cap_sz[i] = 0; end
            first_err = ERR_NONE;
            hash = FNV_BASIS;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] v);
            case (idx)
                REG_NAME_LOW:  name_lo = v;
                REG_NAME_HIGH: name_hi = v;
                REG_SIZE_X:    gx = v[31:0];
                REG_SIZE_Y:    gy = v[31:0];
                REG_SIZE_Z:    gz = v[31:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] name_byte(int unsigned idx);
            if (idx >= 15) return 8'd0;
            if (idx < 8) return name_lo[8*idx +: 8];
            return name_hi[8*(idx-8) +: 8];
        endfunction

        function void walk(logic [31:0] w);
            logic [7:0] c;
            if (left == 0) begin
                if (w[31:16] == 0) begin first_err = ERR_LENGTH; return; end
                len = w[31:16]; pos = 0; left = w[31:16] - 1;
                c_entry = (w[15:0] == OP_ENTRY) && (w[31:16] >= 4);
                c_ended = 0;
                c_mode = (w[15:0] == OP_MODE) && (w[31:16] == 6);
            end else begin
                pos = pos + 1; left = left - 1;
                if (c_entry) begin
                    if (pos == 1) begin
                        if (w != MODEL_GLCOMPUTE) c_entry = 0;
                    end else if (pos == 2) begin
                        pend_id = w;
                    end else if (!c_ended) begin
                        for (int b = 0; b < 4; b++) begin
                            c = w[8*b +: 8];
                            if (c != name_byte((int'(pos) - 3) * 4 + b)) begin
                                c_entry = 0; break;
                            end
                            if (c == 0) begin c_ended = 1; break; end
                        end
                    end
                end
                if (c_mode) begin
                    if (pos == 1) pend_id = w;
                    else if (pos == 2) begin
                        if (w != MODE_LOCAL_SIZE) c_mode = 0;
                    end else if (pos <= 5) pend_sz[pos-3] = w;
                end
            end
            if (left == 0) begin
                if (c_entry && (c_ended || name_byte((int'(len) - 3) * 4) == 0)) begin
                    entry_found = 1; entry_id = pend_id;
                end
                if (c_mode && entry_found && pend_id == entry_id) begin
                    for (int i = 0; i < 3; i++) cap_sz[i] = pend_sz[i];
                    size_found = 1;
                end
            end
        endfunction

        // Note one accepted word; queue a verdict on the last one.
        function void note_word(logic [31:0] w, logic last);
            verdict_t v;
            logic shape_bad;
            err_t e;
            for (int b = 0; b < 4; b++)
                hash = (hash ^ {56'd0, w[8*b +: 8]}) * 64'd1099511628211;
            if (first_err == ERR_NONE) begin
                if (widx == 0) begin
                    if (w != SPV_MAGIC) first_err = ERR_MAGIC;
                end else if (widx >= HEADER_WORDS) walk(w);
            end
            if (!last) begin
                if (widx != 32'hffff_ffff) widx++;
                return;
            end
            if (first_err == ERR_NONE) begin
                if (widx < 4) first_err = ERR_MAGIC;
                else if (left != 0) first_err = ERR_LENGTH;
            end
            shape_bad = gx == 0 || gy == 0 || gz == 0 || name_byte(0) == 0;
            if (shape_bad) e = ERR_SHAPE;
            else if (first_err != ERR_NONE) e = err_t'(first_err);
            else if (!entry_found) e = ERR_NO_ENTRY;
            else if (!size_found) e = ERR_NO_SIZE;
            else if (cap_sz[0] != gx || cap_sz[1] != gy || cap_sz[2] != gz) e = ERR_MISMATCH;
            else e = ERR_NONE;
            v.ok = (e == ERR_NONE);
            v.code = e;
            v.sx = (!shape_bad && size_found) ? cap_sz[0] : 32'd0;
            v.sy = (!shape_bad && size_found) ? cap_sz[1] : 32'd0;
            v.sz = (!shape_bad && size_found) ? cap_sz[2] : 32'd0;
            v.hash = v.ok ? hash : 64'd0;
            pending_q.insert(pending_q.size(), v);
            clear_stream();
        endfunction

        function void check_result(verdict_t got);
            verdict_t x;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (got.ok !== x.ok) begin
                $error("module_ok exp %0h got %0h", x.ok, got.ok); errors++;
            end
            if (got.code !== x.code) begin
                $error("error_code exp %0d got %0d", x.code, got.code); errors++;
            end
            if (got.sx !== x.sx) begin
                $error("found_size_x exp %0h got %0h", x.sx, got.sx); errors++;
            end
            if (got.sy !== x.sy) begin
                $error("found_size_y exp %0h got %0h", x.sy, got.sy); errors++;
            end
            if (got.sz !== x.sz) begin
                $error("found_size_z exp %0h got %0h", x.sz, got.sz); errors++;
            end
            if (got.hash !== x.hash) begin
                $error("module_hash exp %0h got %0h", x.hash, got.hash); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] module_word = '0;
    logic        last_word = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        module_ok;
    logic [2:0]  error_code;
    logic [31:0] found_size_x, found_size_y, found_size_z;
    logic [63:0] module_hash;

    module_scoreboard sb = new();
    int  words_sent = 0;
    bit  hold_off = 0;     // long receiver hold-off request
    bit  hold_used = 0;

    // Module image under construction
    logic [31:0] img[$];

    // Append one word to the image.
    function automatic void add_word(logic [31:0] w);
        img.insert(img.size(), w);
    endfunction

    always #4 clk = ~clk;

    spirv_compute_module_check i_dut (.*);

    // Draw an idle gap: mostly none or short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_cfg(reg_idx_t idx, logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_write <= 0;
        sb.write_reg(idx, v);
    endtask

    // Offer one beat and hold it until taken; drop valid only for a gap.
    task automatic send_word(logic [31:0] w, logic last, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1; module_word <= w; last_word <= last;
        do @(posedge clk); while (in_stall);
        sb.note_word(w, last);
        words_sent++;
    endtask

    task automatic send_image(bit no_gap);
        foreach (img[i]) send_word(img[i], i == img.size() - 1, no_gap);
        in_valid <= 0;
        @(posedge clk);
    endtask

    // Drain: wait for every verdict, then cover the tail of the pipeline.
    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic put_header();
        img.delete();
        add_word(SPV_MAGIC);
        repeat (4) add_word($urandom());
    endtask

    // Append an entry point carrying the configured name (or a damaged one).
    task automatic put_entry(logic [31:0] id, int name_len, bit spoil, bit pad_word);
        logic [7:0]  nb[$];
        logic [31:0] w;
        int nw;
        for (int i = 0; i < name_len; i++) nb.insert(nb.size(), sb.name_byte(i));
        if (spoil && name_len > 0) nb[$urandom_range(0, name_len - 1)] ^= 8'h01;
        nw = (name_len + 4) / 4 + (pad_word ? 1 : 0);
        add_word({16'(3 + nw), OP_ENTRY});
        add_word($urandom_range(0, 7) == 0 ? 32'd0 : MODEL_GLCOMPUTE);
        add_word(id);
        for (int k = 0; k < nw; k++) begin
            w = 0;
            for (int b = 0; b < 4; b++)
                if (k*4 + b < nb.size()) w[8*b +: 8] = nb[k*4 + b];
            add_word(w);
        end
    endtask

    task automatic put_size(logic [31:0] id, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        add_word({16'd6, OP_MODE});
        add_word(id);
        add_word(MODE_LOCAL_SIZE);
        add_word(x); add_word(y); add_word(z);
    endtask

    task automatic put_filler();
        int n;
        n = $urandom_range(1, 4);
        add_word({16'(n), 16'($urandom_range(0, 20))});
        repeat (n - 1) add_word($urandom());
    endtask

    task automatic set_name(int name_len);
        logic [63:0] lo, hi;
        lo = 0; hi = 0;
        for (int i = 0; i < name_len; i++) begin
            if (i < 8) lo[8*i +: 8] = $urandom_range(1, 255);
            else hi[8*(i-8) +: 8] = $urandom_range(1, 255);
        end
        write_cfg(REG_NAME_LOW, lo);
        write_cfg(REG_NAME_HIGH, hi);
    endtask

    // A random module: mostly well formed with random content.
    task automatic build_random();
        logic [31:0] id;
        int r;
        id = $urandom_range(0, 3);
        put_header();
        repeat ($urandom_range(0, 2)) put_filler();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            if ($urandom_range(0, 9) == 0) put_size(id, sb.gx, sb.gy, sb.gz);
            put_entry(id, $urandom_range(1, 15), $urandom_range(0, 9) == 0,
                      $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) != 0)
                put_size($urandom_range(0, 7) == 0 ? id + 1 : id,
                         $urandom_range(0, 7) == 0 ? $urandom() : sb.gx,
                         sb.gy, $urandom_range(0, 7) == 0 ? 32'd0 : sb.gz);
            repeat ($urandom_range(0, 2)) put_filler();
        end else if (r < 80) begin
            repeat ($urandom_range(0, 8)) add_word($urandom());
        end else if (r < 88) begin
            add_word({16'd0, 16'($urandom())});
            add_word($urandom());
        end else if (r < 94) begin
            add_word({16'd9, OP_ENTRY});
            add_word(MODEL_GLCOMPUTE);
        end else begin
            img.delete();
            repeat ($urandom_range(1, 5)) add_word($urandom());
            if ($urandom_range(0, 1)) img[0] = SPV_MAGIC;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int g;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0) begin
                out_stall <= 1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    // Monitor: compare every accepted result beat.
    always @(posedge clk) begin
        verdict_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.ok = module_ok; got.code = err_t'(error_code);
            got.sx = found_size_x; got.sy = found_size_y; got.sz = found_size_z;
            got.hash = module_hash;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset settings: empty name is a shape error.
        put_header(); put_entry(1, 4, 0, 0); put_size(1, 1, 1, 1);
        send_image(0);
        drain();

        // Short name, exact match; then every error case but the shape error.
        set_name(4);
        write_cfg(REG_SIZE_X, 8); write_cfg(REG_SIZE_Y, 4); write_cfg(REG_SIZE_Z, 2);
        put_header(); put_entry(3, 4, 0, 0); put_size(3, 8, 4, 2); send_image(0);
        put_header(); put_entry(3, 4, 0, 0); put_size(3, 8, 4, 3); send_image(0);
        put_header(); put_entry(3, 4, 0, 0); send_image(0);
        put_header(); put_entry(3, 4, 1, 0); put_size(3, 8, 4, 2); send_image(0);
        put_header(); put_size(3, 8, 4, 2); put_entry(3, 4, 0, 0); send_image(0);
        put_header(); img[0] = 32'hffff_ffff; send_image(0);
        img.delete(); add_word(SPV_MAGIC); add_word(0); send_image(0);
        put_header(); add_word(32'h0000_0011); send_image(0);
        put_header(); add_word({16'd5, OP_ENTRY}); send_image(0);
        // Repeated match replaces the id and sizes.
        put_header(); put_entry(1, 4, 0, 0); put_entry(2, 4, 0, 1);
        put_size(1, 8, 4, 2); put_size(2, 8, 4, 1); put_size(2, 8, 4, 2); send_image(0);
        drain();

        // Longest name, byte 15 set but ignored; all-ones sizes.
        set_name(15);
        write_cfg(REG_NAME_HIGH, sb.name_hi | 64'hff00_0000_0000_0000);
        write_cfg(REG_SIZE_X, 32'hffff_ffff); write_cfg(REG_SIZE_Y, 32'hffff_ffff);
        write_cfg(REG_SIZE_Z, 32'hffff_ffff);
        put_header(); put_entry(32'hffff_ffff, 15, 0, 0);
        put_size(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_image(0);
        drain();
        write_cfg(REG_SIZE_Y, 0);
        put_header(); put_entry(0, 15, 0, 0); put_size(0, 32'hffff_ffff, 0, 0);
        send_image(0);
        drain();

        // Random phases under a range of settings.
        for (int ph = 0; ph < 6; ph++) begin
            set_name($urandom_range(1, 15));
            write_cfg(REG_SIZE_X, ph == 5 ? 32'd0 : $urandom_range(1, 1024));
            write_cfg(REG_SIZE_Y, $urandom());
            write_cfg(REG_SIZE_Z, $urandom_range(1, 64));
            while (words_sent < 300 * (ph + 1)) begin
                build_random();
                if (ph == 2 && !hold_used && words_sent > 700) begin
                    hold_off = 1;
                    hold_used = 1;
                end
                send_image(hold_off);
            end
            drain();
        end
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
